[src/lpht_pkg.sv]
// Shared constants, types and status codes for the linear probe hash table.
package lpht_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int KEY_BITS    = 32;
   localparam int VALUE_BITS  = 32;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
   localparam int STATUS_BITS = 3;

   // Remainder unit: key bits consumed per cycle
   localparam int MOD_DIGIT    = 4;
   localparam int MOD_STEPS    = (KEY_BITS + MOD_DIGIT - 1) / MOD_DIGIT;
   localparam int MOD_PAD      = MOD_STEPS * MOD_DIGIT;
   localparam int MOD_CNT_BITS = $clog2(MOD_STEPS);

   localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_UPDATED   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic                  occ;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   typedef struct packed {
      logic                en;
      logic [IDX_BITS-1:0] addr;
      entry_type           data;
   } mem_wr_type;

   typedef struct packed {
      logic                en;
      logic [IDX_BITS-1:0] addr;
   } mem_rd_type;

endpackage

[src/lpht_mod.sv]
// Multi-cycle key remainder unit: key modulo bucket count, four bits a cycle.
module lpht_mod
   import lpht_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [KEY_BITS-1:0] dividend,
   input  logic [CNT_BITS-1:0] divisor,
   output logic                done,
   output logic [IDX_BITS-1:0] remainder
);

   logic [MOD_PAD-1:0]      shift_ff, shift_in;
   logic [IDX_BITS-1:0]     rem_ff, rem_in;
   logic [CNT_BITS-1:0]     divisor_ff;
   logic [MOD_CNT_BITS-1:0] step_ff, step_in;
   logic                    run_ff, run_in;
   logic                    done_ff, done_in;

   always_comb begin
      logic [CNT_BITS-1:0] t;
      logic [IDX_BITS-1:0] r;
      logic [MOD_PAD-1:0]  sh;
      r  = rem_ff;
      sh = shift_ff;
      for (int i = 0; i < MOD_DIGIT; i++) begin
         t  = {r, sh[MOD_PAD-1]};
         sh = {sh[MOD_PAD-2:0], 1'b0};
         if (t >= divisor_ff) begin
            t = t - divisor_ff;
         end
         r = t[IDX_BITS-1:0];
      end
      shift_in = shift_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = MOD_PAD'(dividend);
         rem_in   = '0;
         step_in  = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         shift_in = sh;
         rem_in   = r;
         step_in  = step_ff + 1'b1;
         if (step_ff == MOD_CNT_BITS'(MOD_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      if (start) begin
         divisor_ff <= divisor;
      end
      if (reset) begin
         step_ff <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[src/lpht_mem.sv]
// Bucket store: valid mark, key and value per bucket, one write and one registered read port.
module lpht_mem
   import lpht_pkg::*;
(
   input  logic       clock,
   input  mem_wr_type wr,
   input  mem_rd_type rd,
   output entry_type  rd_data
);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/linear_probe_hash_table.sv]
// Top level of the linear probe hash table: request sequencer, probe walk and result register.
//
// Usage
//  - Request: drive req_mode (0 lookup, 1 insert or update), req_key and req_value with
//    start high; the transfer happens at an edge where busy is low. busy then stays high
//    until the result is out.
//  - Result: rsp_valid is high for exactly one cycle with rsp_status, rsp_read_value,
//    rsp_bucket and rsp_entry_count. The receiver cannot stall; take it in that cycle.
//  - Configuration: csr_bucket_count is written whenever csr_valid is high (csr_ready is
//    always high). Write it only while no request is outstanding. Zero acts as one,
//    values above 1024 act as 1024.
//  - Timing: the home bucket comes from a remainder unit (four key bits a cycle), then
//    one bucket memory read per probe; a request probes from one bucket up to the bucket
//    count. busy falls in the same cycle as the strobe; the single read port sets the
//    probe rate.
//  - Reset: a clearing pass writes every bucket empty with busy high; the entry count
//    returns to zero and bucket count to 1024.
module linear_probe_hash_table
   import lpht_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_mode,
   input  logic [KEY_BITS-1:0]    req_key,
   input  logic [VALUE_BITS-1:0]  req_value,
   output logic                   rsp_valid,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [VALUE_BITS-1:0]  rsp_read_value,
   output logic [IDX_BITS-1:0]    rsp_bucket,
   output logic [CNT_BITS-1:0]    rsp_entry_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CNT_BITS-1:0]    csr_bucket_count
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_MOD   = 2'd2;
   localparam logic [1:0] S_PROBE = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [IDX_BITS-1:0]    clr_addr_ff, clr_addr_in;
   logic [CNT_BITS-1:0]    bucket_count_ff;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   mode_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [VALUE_BITS-1:0]  value_ff;
   logic [IDX_BITS-1:0]    home_ff, home_in;
   logic [IDX_BITS-1:0]    j_ff, j_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_BITS-1:0]  rsp_value_ff, rsp_value_in;
   logic [IDX_BITS-1:0]    rsp_bucket_ff, rsp_bucket_in;

   logic [CNT_BITS-1:0]    n_eff;
   logic                   accept;
   logic                   mod_done;
   logic [IDX_BITS-1:0]    mod_rem;
   mem_wr_type             mem_wr;
   mem_rd_type             mem_rd;
   entry_type              rd_data;

   logic                   hit;
   logic                   stop_here;
   logic [CNT_BITS-1:0]    j_inc;
   logic [IDX_BITS-1:0]    j_wrap;
   logic                   wrapped_home;
   logic                   occ_f;
   logic                   hit_f;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      if (bucket_count_ff == '0) begin
         n_eff = CNT_BITS'(1);
      end else if (bucket_count_ff > CNT_BITS'(TABLE_DEPTH)) begin
         n_eff = CNT_BITS'(TABLE_DEPTH);
      end else begin
         n_eff = bucket_count_ff;
      end
   end

   lpht_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (req_key),
      .divisor   (n_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   lpht_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (rd_data)
   );

   // Probe decision on the bucket read in the previous cycle
   assign hit          = rd_data.occ && (rd_data.key == key_ff);
   assign stop_here    = !rd_data.occ || hit;
   assign j_inc        = {1'b0, j_ff} + 1'b1;
   assign j_wrap       = (j_inc >= n_eff) ? '0 : j_inc[IDX_BITS-1:0];
   assign wrapped_home = (j_wrap == home_ff);
   assign occ_f        = stop_here ? rd_data.occ : 1'b1;
   assign hit_f        = stop_here ? hit : 1'b0;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      count_in      = count_ff;
      home_in       = home_ff;
      j_in          = j_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_bucket_in = rsp_bucket_ff;
      mem_wr        = '0;
      mem_rd        = '0;

      case (state_ff)
         S_CLEAR: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == IDX_BITS'(TABLE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               mem_rd.en   = 1'b1;
               mem_rd.addr = mod_rem;
               home_in     = mod_rem;
               j_in        = mod_rem;
               state_in    = S_PROBE;
            end
         end
         S_PROBE: begin
            if (stop_here || wrapped_home) begin
               // finish: a full wrap stops back at the home bucket
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_bucket_in = stop_here ? j_ff : home_ff;
               rsp_value_in  = '0;
               mem_wr.addr   = j_ff;
               mem_wr.data   = '{occ: 1'b1, key: key_ff, value: value_ff};
               if (!mode_ff) begin
                  rsp_status_in = hit_f ? ST_FOUND : ST_NOT_FOUND;
                  if (hit_f) begin
                     rsp_value_in = rd_data.value;
                  end
               end else if (!occ_f) begin
                  rsp_status_in = ST_INSERTED;
                  mem_wr.en     = 1'b1;
                  count_in      = count_ff + 1'b1;
               end else if (hit_f) begin
                  rsp_status_in = ST_UPDATED;
                  mem_wr.en     = 1'b1;
               end else begin
                  rsp_status_in = ST_FULL;
               end
            end else begin
               // advance to the next bucket
               mem_rd.en   = 1'b1;
               mem_rd.addr = j_wrap;
               j_in        = j_wrap;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      home_ff       <= home_in;
      j_ff          <= j_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_bucket_ff <= rsp_bucket_in;
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_addr_ff     <= '0;
         count_ff        <= '0;
         bucket_count_ff <= CNT_BITS'(TABLE_DEPTH);
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            bucket_count_ff <= csr_bucket_count;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_bucket      = rsp_bucket_ff;
   assign rsp_entry_count = count_ff;

   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a request transfer");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= CNT_BITS'(TABLE_DEPTH)))
      else $error("entry count beyond table depth");

   a_value_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_FOUND)) |-> (rsp_read_value == '0))
      else $error("read value not zero on a result other than found");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for linear_probe_hash_table: a shadow table predicts every request.
module tb_top;
   import lpht_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_INSERT = 1'b1;
   localparam int   STALL_LIMIT   = 20000;
   localparam int   SETTLE_CYCLES = 4;
   localparam int   TAIL_CYCLES   = 20;

   typedef struct packed {
      logic                  mode;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } request_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [VALUE_BITS-1:0]  read_value;
      logic [IDX_BITS-1:0]    bucket;
      logic [CNT_BITS-1:0]    entry_count;
   } access_result_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_mode;
   logic [KEY_BITS-1:0]    req_key;
   logic [VALUE_BITS-1:0]  req_value;
   logic                   rsp_valid;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [VALUE_BITS-1:0]  rsp_read_value;
   logic [IDX_BITS-1:0]    rsp_bucket;
   logic [CNT_BITS-1:0]    rsp_entry_count;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CNT_BITS-1:0]    csr_bucket_count;

   // Shadow copy of the table and its divisor
   logic                  shadow_occupied [TABLE_DEPTH];
   logic [KEY_BITS-1:0]   shadow_key      [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] shadow_value    [TABLE_DEPTH];
   logic [CNT_BITS-1:0]   shadow_count;
   logic [CNT_BITS-1:0]   shadow_buckets;

   request_type       pending_requests [$];
   access_result_type expected_results [$];
   request_type       held_request;
   int unsigned       sender_idle_pct;
   int unsigned       stalled_cycles;
   int unsigned       error_count;

   linear_probe_hash_table dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_key          (req_key),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .rsp_bucket       (rsp_bucket),
      .rsp_entry_count  (rsp_entry_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_bucket_count (csr_bucket_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Walk the shadow table exactly as the block must, and apply the request
   function automatic access_result_type predict_access(request_type r);
      int unsigned       span;
      int unsigned       home;
      int unsigned       slot;
      bit                stop;
      bit                hit;
      access_result_type res;
      if (shadow_buckets == 0)
         span = 1;
      else if (shadow_buckets > TABLE_DEPTH)
         span = TABLE_DEPTH;
      else
         span = shadow_buckets;
      home = r.key % span;
      slot = home;
      stop = 1'b0;
      while (!stop) begin
         if (!shadow_occupied[slot] || shadow_key[slot] == r.key) begin
            stop = 1'b1;
         end else begin
            slot = (slot + 1 == span) ? 0 : slot + 1;
            if (slot == home)
               stop = 1'b1;
         end
      end
      hit = shadow_occupied[slot] && shadow_key[slot] == r.key;
      res.read_value = '0;
      if (r.mode == MODE_LOOKUP) begin
         if (hit) begin
            res.status     = ST_FOUND;
            res.read_value = shadow_value[slot];
         end else begin
            res.status = ST_NOT_FOUND;
         end
      end else if (!shadow_occupied[slot]) begin
         shadow_occupied[slot] = 1'b1;
         shadow_key[slot]      = r.key;
         shadow_value[slot]    = r.value;
         shadow_count          = shadow_count + 1'b1;
         res.status            = ST_INSERTED;
      end else if (hit) begin
         shadow_value[slot] = r.value;
         res.status         = ST_UPDATED;
      end else begin
         res.status = ST_FULL;
      end
      res.bucket      = slot[IDX_BITS-1:0];
      res.entry_count = shadow_count;
      return res;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   // Request driver: hold start until the transfer, then load the next request or go idle
   always @(posedge clock) begin : drive_requests
      if (reset) begin
         start <= 1'b0;
      end else if (!start || busy === 1'b0) begin
         if (start)
            expected_results.push_back(predict_access(held_request));
         if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            held_request = pending_requests.pop_front();
            start     <= 1'b1;
            req_mode  <= held_request.mode;
            req_key   <= held_request.key;
            req_value <= held_request.value;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Result monitor, divisor tracking and stall counter
   always @(posedge clock) begin : observe_results
      access_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_results.size() == 0) begin
            $error("result with no request outstanding: status %0h bucket %0h",
                   rsp_status, rsp_bucket);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("read_value", want.read_value, rsp_read_value);
            check_field("bucket", 32'(want.bucket), 32'(rsp_bucket));
            check_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
         end
      end
      if (!reset && csr_valid && csr_ready === 1'b1)
         shadow_buckets = csr_bucket_count;
      if (reset || rsp_valid === 1'b1 || (start && busy === 1'b0) ||
          (csr_valid && csr_ready === 1'b1))
         stalled_cycles = 0;
      else
         stalled_cycles++;
   end

   initial begin : watchdog
      wait (stalled_cycles >= STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic wait_until_quiet();
      do
         @(negedge clock);
      while (pending_requests.size() != 0 || start || busy !== 1'b0 ||
             expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_bucket_count(logic [CNT_BITS-1:0] buckets);
      @(posedge clock);
      csr_valid        <= 1'b1;
      csr_bucket_count <= buckets;
      do
         @(posedge clock);
      while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic queue_request(logic mode, logic [KEY_BITS-1:0] key,
                                logic [VALUE_BITS-1:0] value);
      request_type r;
      r.mode  = mode;
      r.key   = key;
      r.value = value;
      pending_requests.push_back(r);
   endtask

   // Random traffic over a small key pool so that hits, updates and collisions are common
   task automatic random_phase(logic [CNT_BITS-1:0] buckets, int unsigned idle_pct,
                               int unsigned n_items);
      logic [KEY_BITS-1:0] pool [$];
      int unsigned         span;
      int unsigned         pool_size;
      logic [KEY_BITS-1:0] key;
      span = (buckets == 0) ? 1 : ((buckets > TABLE_DEPTH) ? TABLE_DEPTH : buckets);
      pool_size = (span < 16) ? 2 * span + 2 : 48;
      wait_until_quiet();
      set_bucket_count(buckets);
      sender_idle_pct = idle_pct;
      repeat (pool_size)
         pool.push_back($urandom_range(1) ? $urandom : $urandom_range(4 * span));
      repeat (n_items) begin
         key = ($urandom_range(99) < 85) ? pool[$urandom_range(pool_size - 1)] : $urandom;
         queue_request($urandom_range(1) ? MODE_INSERT : MODE_LOOKUP, key, $urandom);
      end
   endtask

   initial begin : stimulus
      int unsigned phase_buckets [12];
      int unsigned phase_idle    [12];
      int unsigned phase_items   [12];
      phase_buckets = '{1, 2, 3, 7, 16, 31, 100, 1023, 1024, 1025, 0, 64};
      phase_idle    = '{0, 66, 36, 0, 66, 36, 0, 66, 36, 0, 66, 0};
      phase_items   = '{30, 30, 40, 60, 60, 80, 80, 80, 80, 60, 70, 80};
      phase_buckets[10] = $urandom_range(2047, 1);

      reset            = 1'b1;
      start            = 1'b0;
      req_mode         = MODE_LOOKUP;
      req_key          = '0;
      req_value        = '0;
      csr_valid        = 1'b0;
      csr_bucket_count = '0;
      sender_idle_pct  = 0;
      stalled_cycles   = 0;
      error_count      = 0;
      shadow_count     = '0;
      shadow_buckets   = CNT_BITS'(TABLE_DEPTH);
      for (int i = 0; i < TABLE_DEPTH; i++)
         shadow_occupied[i] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Default divisor: empty lookup, key extremes, a collision and an update
      queue_request(MODE_LOOKUP, 32'h0000_0000, 32'h0);
      queue_request(MODE_INSERT, 32'h0000_0000, 32'h0000_0000);
      queue_request(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_request(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      queue_request(MODE_INSERT, 32'd1024, 32'h5A5A_5A5A);
      queue_request(MODE_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
      queue_request(MODE_LOOKUP, 32'd1024, 32'h0);
      queue_request(MODE_LOOKUP, 32'd2048, 32'h0);
      wait_until_quiet();

      // Zero acts as one bucket, which is already taken: full table cases
      set_bucket_count('0);
      queue_request(MODE_INSERT, 32'd7, 32'h0000_0001);
      queue_request(MODE_LOOKUP, 32'd5, 32'h0);
      queue_request(MODE_LOOKUP, 32'h0000_0000, 32'h0);
      queue_request(MODE_INSERT, 32'h0000_0000, 32'h0000_0003);
      wait_until_quiet();

      // Oversized divisor saturates; earlier entries are still reachable
      set_bucket_count(11'h7FF);
      queue_request(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      queue_request(MODE_LOOKUP, 32'd1024, 32'h0);
      queue_request(MODE_INSERT, 32'h8000_0000, 32'h1234_5678);
      queue_request(MODE_LOOKUP, 32'h8000_0000, 32'h0);

      for (int p = 0; p < 12; p++)
         random_phase(CNT_BITS'(phase_buckets[p]), phase_idle[p], phase_items[p]);

      wait_until_quiet();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d results never arrived", expected_results.size());
         error_count++;
      end
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
